// ----- sv/vpic_pkg.sv -----
// Shared types, register offsets and word packing helpers of the vectored interrupt controller.
package vpic_pkg;

   typedef enum logic [2:0] {
      CMD_READ     = 3'd0,
      CMD_WRITE    = 3'd1,
      CMD_LEVEL    = 3'd2,
      CMD_ACK      = 3'd3,
      CMD_COMPLETE = 3'd4
   } cmd_type;

   localparam logic [7:0] OFF_CONTROL    = 8'h00;
   localparam logic [7:0] OFF_STATUS     = 8'h04;
   localparam logic [7:0] OFF_PEND_LO    = 8'h08;
   localparam logic [7:0] OFF_PEND_HI    = 8'h0c;
   localparam logic [7:0] OFF_PRIO_FIRST = 8'h10;
   localparam logic [7:0] OFF_PRIO_LAST  = 8'h2f;
   localparam logic [7:0] OFF_VBASE      = 8'h30;
   localparam logic [7:0] OFF_WAKEUP     = 8'h34;
   localparam logic [7:0] OFF_PROFILE    = 8'h38;
   localparam logic [7:0] OFF_FORCE_LO   = 8'h40;
   localparam logic [7:0] OFF_FORCE_HI   = 8'h44;
   localparam logic [7:0] OFF_SET_LO     = 8'h48;
   localparam logic [7:0] OFF_SET_HI     = 8'h4c;
   localparam logic [7:0] OFF_CLR_LO     = 8'h50;
   localparam logic [7:0] OFF_CLR_HI     = 8'h54;

   localparam int          MAX_SOURCES  = 64;
   localparam int          PRIO_WORDS   = 8;
   localparam logic [30:0] WAKEUP_RESET = 31'h0800_0000;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  offset;
      logic [31:0] write_data;
      logic [5:0]  source_index;
      logic        source_level;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] source;
      logic [2:0] level;
   } win_type;

   typedef struct packed {
      logic [MAX_SOURCES-1:0]       req;
      logic [2:0]                   threshold;
      logic [PRIO_WORDS-1:0][23:0]  prio;
   } arb_in_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        ack_granted;
      logic [6:0]  ack_vector;
      logic [31:0] ack_vector_base;
      logic        bad_access;
   } exec_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_out;
      logic        ack_granted;
      logic [6:0]  ack_vector;
      logic [31:0] ack_vector_base;
      logic        bad_access;
   } result_type;

   function automatic logic [31:0] expand_word(input logic [23:0] w);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[4*i +: 3] = w[3*i +: 3];
      end
      return r;
   endfunction

   function automatic logic [23:0] pack_word(input logic [31:0] v);
      logic [23:0] r;
      for (int i = 0; i < 8; i++) begin
         r[3*i +: 3] = v[4*i +: 3];
      end
      return r;
   endfunction

   function automatic logic [10:0] status_field(input logic valid, input logic [5:0] src,
                                                input logic [2:0] lvl);
      return valid ? {lvl, 1'b0, 1'b1, src} : 11'd0;
   endfunction

endpackage

// ----- sv/vectored_priority_interrupt_controller.sv -----
// Top level of the vectored priority interrupt controller: request, execute and result stages.
// The block takes one request per cycle and returns one result per request, in order; a result
// is registered in the execute and then the result stage, and a stalled rsp_tready holds the
// pipeline back without losing anything. The execute stage reads the arbitration tree that runs
// over all 64 sources from the state registers, and that same tree gives the irq_out level that
// a result carries as it is registered, so each request sees the state all earlier requests left.
module vectored_priority_interrupt_controller #(
   parameter int NUM_SOURCES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // offset, write_data, source_index, source_level, zero fill
   input  logic [47:0] req_tdata,
   // command
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data, irq_out, ack_granted, ack_vector, ack_vector_base, bad_access, zero fill
   output logic [79:0] rsp_tdata
);
   import vpic_pkg::*;

   logic       req_valid_ff;
   item_type   req_item_ff, req_item_in;
   logic       exec_valid_ff;
   exec_type   exec_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       rsp_free;
   logic       exec_free;
   logic       exec_en;
   logic       move_rsp;
   arb_in_type arb_in;
   win_type    win;
   exec_type   exec_result;
   logic       active_valid;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign move_rsp   = exec_valid_ff && rsp_free;
   assign exec_free  = !exec_valid_ff || rsp_free;
   assign exec_en    = req_valid_ff && exec_free;
   assign req_tready = !req_valid_ff || exec_free;

   assign req_item_in.command      = cmd_type'(req_tuser);
   assign req_item_in.offset       = req_tdata[7:0];
   assign req_item_in.write_data   = req_tdata[39:8];
   assign req_item_in.source_index = req_tdata[45:40];
   assign req_item_in.source_level = req_tdata[46];

   vpic_arbiter #(
      .NUM_SOURCES(NUM_SOURCES)
   ) u_arbiter (
      .arb_in(arb_in),
      .win   (win)
   );

   vpic_regs #(
      .NUM_SOURCES(NUM_SOURCES)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .exec_en     (exec_en),
      .item        (req_item_ff),
      .win         (win),
      .arb_in      (arb_in),
      .result      (exec_result),
      .active_valid(active_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (exec_free) begin
            exec_valid_ff <= req_valid_ff;
         end
         if (rsp_free) begin
            rsp_valid_ff <= exec_valid_ff;
         end
      end
      if (req_tready && req_tvalid) begin
         req_item_ff <= req_item_in;
      end
      if (exec_en) begin
         exec_ff <= exec_result;
      end
      if (move_rsp) begin
         rsp_ff.read_data       <= exec_ff.read_data;
         rsp_ff.irq_out         <= !active_valid && win.valid;
         rsp_ff.ack_granted     <= exec_ff.ack_granted;
         rsp_ff.ack_vector      <= exec_ff.ack_vector;
         rsp_ff.ack_vector_base <= exec_ff.ack_vector_base;
         rsp_ff.bad_access      <= exec_ff.bad_access;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.bad_access, rsp_ff.ack_vector_base, rsp_ff.ack_vector,
                        rsp_ff.ack_granted, rsp_ff.irq_out, rsp_ff.read_data};

   a_grant_drops_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ack_granted |-> !rsp_ff.irq_out && rsp_ff.ack_vector[6])
      else $error("Granted acknowledge left the interrupt request raised.");

   a_no_grant_no_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ack_granted |-> rsp_ff.ack_vector == 7'd0
                                              && rsp_ff.ack_vector_base == 32'd0)
      else $error("Vector returned without a grant.");

   a_bad_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bad_access |-> rsp_ff.read_data == 32'd0 && !rsp_ff.ack_granted)
      else $error("Bad access returned data.");

endmodule

// ----- sv/vpic_arbiter.sv -----
// Priority tree that picks the highest pending source, lowest index on a tie.
module vpic_arbiter #(
   parameter int NUM_SOURCES = 64
) (
   input  vpic_pkg::arb_in_type arb_in,
   output vpic_pkg::win_type    win
);
   import vpic_pkg::*;

   localparam int LEVELS = $clog2(MAX_SOURCES);

   logic [2:0] lvl_node [LEVELS+1][MAX_SOURCES];
   logic [5:0] src_node [LEVELS+1][MAX_SOURCES];

   genvar s, k, i;
   generate
      for (s = 0; s < MAX_SOURCES; s++) begin : g_leaf
         logic [2:0] prio;
         logic       eligible;
         assign prio = arb_in.prio[s / 8][3*(s % 8) +: 3];
         assign eligible = arb_in.req[s] && (s < NUM_SOURCES) && (prio > arb_in.threshold);
         assign lvl_node[0][s] = eligible ? prio : 3'd0;
         assign src_node[0][s] = 6'(s);
      end
      for (k = 0; k < LEVELS; k++) begin : g_level
         for (i = 0; i < (MAX_SOURCES >> (k + 1)); i++) begin : g_node
            logic take_high;
            assign take_high = lvl_node[k][2*i+1] > lvl_node[k][2*i];
            assign lvl_node[k+1][i] = take_high ? lvl_node[k][2*i+1] : lvl_node[k][2*i];
            assign src_node[k+1][i] = take_high ? src_node[k][2*i+1] : src_node[k][2*i];
         end
      end
   endgenerate

   always_comb begin
      win.valid  = lvl_node[LEVELS][0] != 3'd0;
      win.level  = lvl_node[LEVELS][0];
      win.source = win.valid ? src_node[LEVELS][0] : 6'd0;
   end

endmodule

// ----- sv/vpic_regs.sv -----
// Register file, source state and command execution of the interrupt controller.
module vpic_regs #(
   parameter int NUM_SOURCES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 exec_en,
   input  vpic_pkg::item_type   item,
   input  vpic_pkg::win_type    win,
   output vpic_pkg::arb_in_type arb_in,
   output vpic_pkg::exec_type   result,
   output logic                 active_valid
);
   import vpic_pkg::*;

   logic [3:0]                  control_ff, control_in;
   logic [MAX_SOURCES-1:0]      line_ff, line_in;
   logic [MAX_SOURCES-1:0]      force_ff, force_in;
   logic [PRIO_WORDS-1:0][23:0] prio_ff, prio_in;
   logic [22:0]                 vbase_ff, vbase_in;
   logic [30:0]                 wakeup_ff, wakeup_in;
   logic [15:0]                 profile_ff, profile_in;
   logic                        active_valid_ff, active_valid_in;
   logic [5:0]                  active_source_ff, active_source_in;
   logic [2:0]                  active_level_ff, active_level_in;

   logic [7:0]  prio_off;
   logic [2:0]  prio_idx;
   logic        in_prio;
   logic [63:0] pend;
   logic [63:0] data_lo;
   logic [63:0] data_hi;

   assign prio_off = item.offset - OFF_PRIO_FIRST;
   assign prio_idx = prio_off[4:2];
   assign in_prio  = (item.offset >= OFF_PRIO_FIRST) && (item.offset <= OFF_PRIO_LAST);
   assign pend     = line_ff | force_ff;
   assign data_lo  = {32'd0, item.write_data};
   assign data_hi  = {item.write_data, 32'd0};

   always_comb begin
      control_in       = control_ff;
      line_in          = line_ff;
      force_in         = force_ff;
      prio_in          = prio_ff;
      vbase_in         = vbase_ff;
      wakeup_in        = wakeup_ff;
      profile_in       = profile_ff;
      active_valid_in  = active_valid_ff;
      active_source_in = active_source_ff;
      active_level_in  = active_level_ff;
      result           = '0;
      if (exec_en) begin
         unique case (item.command)
            CMD_READ: begin
               if (in_prio) begin
                  result.read_data = expand_word(prio_ff[prio_idx]);
               end else begin
                  unique case (item.offset)
                     OFF_CONTROL: result.read_data = {28'd0, control_ff};
                     OFF_STATUS: begin
                        result.read_data = {5'd0,
                                            status_field(win.valid, win.source, win.level),
                                            5'd0,
                                            active_valid_ff
                                               ? status_field(1'b1, active_source_ff,
                                                              active_level_ff)
                                               : status_field(win.valid, win.source,
                                                              win.level)};
                     end
                     OFF_PEND_LO: result.read_data = pend[31:0];
                     OFF_PEND_HI: result.read_data = pend[63:32];
                     OFF_VBASE:   result.read_data = {vbase_ff, 9'd0};
                     OFF_WAKEUP:  result.read_data = {wakeup_ff, 1'b0};
                     OFF_PROFILE: result.read_data = {16'd0, profile_ff};
                     OFF_FORCE_LO, OFF_SET_LO, OFF_CLR_LO: result.read_data = force_ff[31:0];
                     OFF_FORCE_HI, OFF_SET_HI, OFF_CLR_HI: result.read_data = force_ff[63:32];
                     default: result.bad_access = 1'b1;
                  endcase
               end
            end
            CMD_WRITE: begin
               if (in_prio) begin
                  prio_in[prio_idx] = pack_word(item.write_data);
               end else begin
                  unique case (item.offset)
                     OFF_CONTROL:  control_in = item.write_data[3:0];
                     OFF_VBASE:    vbase_in   = item.write_data[31:9];
                     OFF_WAKEUP:   wakeup_in  = item.write_data[31:1];
                     OFF_PROFILE:  profile_in = item.write_data[15:0];
                     OFF_FORCE_LO: force_in   = {force_ff[63:32], item.write_data};
                     OFF_FORCE_HI: force_in   = {item.write_data, force_ff[31:0]};
                     OFF_SET_LO:   force_in   = force_ff | data_lo;
                     OFF_SET_HI:   force_in   = force_ff | data_hi;
                     OFF_CLR_LO:   force_in   = force_ff & ~data_lo;
                     OFF_CLR_HI:   force_in   = force_ff & ~data_hi;
                     default:      result.bad_access = 1'b1;
                  endcase
               end
            end
            CMD_LEVEL: begin
               if (32'(item.source_index) < NUM_SOURCES) begin
                  line_in[item.source_index] = item.source_level;
               end
            end
            CMD_ACK: begin
               if (!active_valid_ff && win.valid) begin
                  active_valid_in        = 1'b1;
                  active_source_in       = win.source;
                  active_level_in        = win.level;
                  result.ack_granted     = 1'b1;
                  result.ack_vector      = {1'b1, win.source};
                  result.ack_vector_base = {vbase_ff, 9'd0};
               end
            end
            CMD_COMPLETE: begin
               active_valid_in  = 1'b0;
               active_source_in = 6'd0;
               active_level_in  = 3'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff       <= '0;
         line_ff          <= '0;
         force_ff         <= '0;
         prio_ff          <= '0;
         vbase_ff         <= '0;
         wakeup_ff        <= WAKEUP_RESET;
         profile_ff       <= '0;
         active_valid_ff  <= 1'b0;
         active_source_ff <= '0;
         active_level_ff  <= '0;
      end else begin
         control_ff       <= control_in;
         line_ff          <= line_in;
         force_ff         <= force_in;
         prio_ff          <= prio_in;
         vbase_ff         <= vbase_in;
         wakeup_ff        <= wakeup_in;
         profile_ff       <= profile_in;
         active_valid_ff  <= active_valid_in;
         active_source_ff <= active_source_in;
         active_level_ff  <= active_level_in;
      end
   end

   assign arb_in.req       = pend;
   assign arb_in.threshold = control_ff[2:0];
   assign arb_in.prio      = prio_ff;
   assign active_valid     = active_valid_ff;

   a_stable_when_idle: assert property (@(posedge clock) disable iff (reset)
      !exec_en |=> $stable(active_valid_ff) && $stable(force_ff) && $stable(line_ff))
      else $error("State changed without an executed request.");

endmodule
